/* hw/rtl/rpdf_pkg.sv */
// Shared constants and types for the recent packet duplicate filter.
`timescale 1ns / 1ps

package rpdf_pkg;

    // Number of recently accepted packets that are remembered.
    localparam int HISTORY_DEPTH = 10;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int STEP_W        = $clog2(HISTORY_DEPTH + 1);

    // Configuration register map.
    localparam int  PADDR_W       = 3;
    localparam int  PDATA_W       = 32;
    localparam logic [0:0] REG_WINDOW_MS = 1'b0;
    localparam logic [15:0] WINDOW_RESET = 16'd200;

    // One stored ring entry.
    typedef struct packed {
        logic [15:0] address;
        logic [15:0] channel;
        logic [7:0]  command;
        logic [31:0] time_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/rpdf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rpdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/recent_packet_duplicate_filter_unit.sv */
// Top level of the recent packet duplicate filter.
`timescale 1ns / 1ps

// The filter keeps the keys (source address, channel, command) and arrival
// time of the last ten accepted packets in a ring held in a small synchronous
// RAM. Every input transaction produces exactly one output transaction:
// accepted is 0 when some valid ring entry has the same three keys and an age
// (now_ms minus stored time, modulo 2^32) strictly below window_ms, and 1
// otherwise. An accepted packet is written at the ring pointer and the pointer
// advances with wrap; a dropped packet leaves the ring untouched. Each packet
// occupies the block for a scan, in which the single RAM read port delivers
// one entry per cycle and the compare of each entry comes in the cycle after
// its read, and then a final cycle in which the result is loaded into the
// output register and the ring is updated. The next input transaction is
// taken in that final cycle, so a new packet is taken only once the last one
// is through its scan. A stalled output holds the block in its final cycle
// until the output register frees. Valid bits for the ring entries live in
// flip-flops and are cleared by reset, so no clearing pass is needed. window_ms
// resets to 200 and lies at byte address 0 of the APB port; the user must
// write it only while the block is idle, which the block does not enforce.

module recent_packet_duplicate_filter_unit (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [15:0]                      source_address,
    input  logic [15:0]                      channel,
    input  logic [7:0]                       command,
    input  logic [31:0]                      now_ms,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             accepted,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rpdf_pkg::PADDR_W-1:0]     paddr,
    input  logic [rpdf_pkg::PDATA_W-1:0]     pwdata,
    output logic [rpdf_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    logic [rpdf_pkg::STEP_W-1:0]     step_reg;
    logic                            dup_reg;
    rpdf_pkg::entry_t                item_reg;
    logic [rpdf_pkg::IDX_W-1:0]      ring_ptr_reg;
    logic [rpdf_pkg::HISTORY_DEPTH-1:0] valid_reg;
    logic [15:0]                     window_reg;
    logic                            out_valid_reg;
    logic                            out_accepted_reg;

    logic                            in_take;
    logic                            out_free;
    logic                            finish_go;
    logic                            ring_write;
    logic                            rd_en;
    logic [rpdf_pkg::IDX_W-1:0]      rd_addr;
    logic [rpdf_pkg::ENTRY_W-1:0]    rd_word;
    rpdf_pkg::entry_t                rd_entry;
    logic [rpdf_pkg::IDX_W-1:0]      cmp_idx;
    logic [31:0]                     age;
    logic                            hit;
    logic                            cfg_write;

    // ------------------------------------------------------------------
    // Configuration port. pready is tied high, so every access completes
    // in its access phase.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == rpdf_pkg::REG_WINDOW_MS)
        begin
            prdata = {16'd0, window_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= rpdf_pkg::WINDOW_RESET;
        end
        else if (cfg_write && (paddr[2] == rpdf_pkg::REG_WINDOW_MS))
        begin
            window_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The output register frees when it is empty or its
    // transaction completes this cycle. The final cycle of one packet can
    // take the next input, since the ring write lands before its first read.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish_go = (state_reg == S_FINISH) && out_free;
    assign in_stall  = !((state_reg == S_IDLE) || finish_go);
    assign in_take   = in_valid && !in_stall;
    assign ring_write = finish_go && !dup_reg;

    assign out_valid = out_valid_reg;
    assign accepted  = out_accepted_reg;

    // ------------------------------------------------------------------
    // Ring memory. Step s reads entry s; the entry read at step s-1 is
    // compared at step s.
    // ------------------------------------------------------------------
    assign rd_en   = (state_reg == S_SCAN) &&
                     (step_reg < rpdf_pkg::STEP_W'(rpdf_pkg::HISTORY_DEPTH));
    assign rd_addr = step_reg[rpdf_pkg::IDX_W-1:0];
    assign cmp_idx = rpdf_pkg::IDX_W'(step_reg - rpdf_pkg::STEP_W'(1));

    rpdf_ram #(
        .WIDTH (rpdf_pkg::ENTRY_W),
        .DEPTH (rpdf_pkg::HISTORY_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_write),
        .wr_addr (ring_ptr_reg),
        .wr_data (item_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = rpdf_pkg::entry_t'(rd_word);
    assign age      = item_reg.time_ms - rd_entry.time_ms;

    // A stored entry suppresses the packet only when it is valid, all three
    // keys agree and it is strictly younger than the window. An entry whose
    // time lies ahead of now_ms has a huge unsigned age and never matches.
    always_comb
    begin
        hit = valid_reg[cmp_idx] &&
              (rd_entry.address == item_reg.address) &&
              (rd_entry.channel == item_reg.channel) &&
              (rd_entry.command == item_reg.command) &&
              (age < {16'd0, window_reg});
    end

    // ------------------------------------------------------------------
    // Sequencer, ring pointer, valid bits and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            dup_reg          <= 1'b0;
            ring_ptr_reg     <= '0;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_accepted_reg <= 1'b0;
        end
        else
        begin
            // The final cycle reloads the output register itself.
            if (out_valid_reg && !out_stall && !finish_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        state_reg <= S_SCAN;
                        step_reg  <= '0;
                        dup_reg   <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (step_reg != '0)
                    begin
                        dup_reg <= dup_reg | hit;
                    end
                    if (step_reg == rpdf_pkg::STEP_W'(rpdf_pkg::HISTORY_DEPTH))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        step_reg <= step_reg + rpdf_pkg::STEP_W'(1);
                    end
                end
                S_FINISH:
                begin
                    if (finish_go)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_accepted_reg <= !dup_reg;
                        if (!dup_reg)
                        begin
                            valid_reg[ring_ptr_reg] <= 1'b1;
                            if (ring_ptr_reg ==
                                rpdf_pkg::IDX_W'(rpdf_pkg::HISTORY_DEPTH - 1))
                            begin
                                ring_ptr_reg <= '0;
                            end
                            else
                            begin
                                ring_ptr_reg <= ring_ptr_reg + rpdf_pkg::IDX_W'(1);
                            end
                        end
                        if (in_take)
                        begin
                            state_reg <= S_SCAN;
                            step_reg  <= '0;
                            dup_reg   <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Packet keys and time, captured when the input transaction is taken.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.address <= source_address;
            item_reg.channel <= channel;
            item_reg.command <= command;
            item_reg.time_ms <= now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Once a packet is taken the block is busy scanning in the next cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_SCAN) && in_stall)
    else $error("block not scanning after input transaction");

    // A new result appears only out of the final cycle of a packet.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(finish_go))
    else $error("result loaded outside the final cycle");

    // The ring pointer never leaves the ring.
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ptr_reg < rpdf_pkg::IDX_W'(rpdf_pkg::HISTORY_DEPTH))
    else $error("ring pointer out of range");

    // An accepted packet leaves a valid entry where it was written.
    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ring_write |=> valid_reg[$past(ring_ptr_reg)] && out_valid_reg && accepted)
    else $error("accepted packet not recorded");

endmodule

/* tb/rpdf_checker.sv */
// Checker that tracks the packet history and compares every filter verdict.
`timescale 1ns / 1ps

module rpdf_checker (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [15:0]                      source_address,
    input  logic [15:0]                      channel,
    input  logic [7:0]                       command,
    input  logic [31:0]                      now_ms,

    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             accepted,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rpdf_pkg::PADDR_W-1:0]     paddr,
    input  logic [rpdf_pkg::PDATA_W-1:0]     pwdata,
    input  logic                             pready,

    output int                               fail_count,
    output int                               outstanding
);

    rpdf_pkg::entry_t history       [rpdf_pkg::HISTORY_DEPTH];
    logic             history_valid [rpdf_pkg::HISTORY_DEPTH];
    int               write_slot;
    logic [15:0]      window;
    logic             expected_accepts [$];
    logic             wanted;
    int               failures;

    // Decides whether a packet is new and records it in the history when it is.
    function automatic logic screen_packet(input logic [15:0] addr,
                                           input logic [15:0] chan,
                                           input logic [7:0]  cmd,
                                           input logic [31:0] stamp);
        logic        dup;
        logic [31:0] age;
        dup = 1'b0;
        for (int k = 0; k < rpdf_pkg::HISTORY_DEPTH; k++) begin
            age = stamp - history[k].time_ms;
            if (history_valid[k] && history[k].address == addr &&
                history[k].channel == chan && history[k].command == cmd &&
                age < {16'd0, window})
                dup = 1'b1;
        end
        if (!dup) begin
            history[write_slot].address = addr;
            history[write_slot].channel = chan;
            history[write_slot].command = cmd;
            history[write_slot].time_ms = stamp;
            history_valid[write_slot]   = 1'b1;
            write_slot = (write_slot == rpdf_pkg::HISTORY_DEPTH - 1) ? 0 : write_slot + 1;
        end
        return !dup;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < rpdf_pkg::HISTORY_DEPTH; k++) begin
                history[k]       = '0;
                history_valid[k] = 1'b0;
            end
            write_slot = 0;
            window     = rpdf_pkg::WINDOW_RESET;
            failures   = 0;
            expected_accepts.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_accepts.size() == 0) begin
                    failures++;
                    $error("accepted: expected none, actual %0b", accepted);
                end
                else begin
                    wanted = expected_accepts.pop_front();
                    if (accepted !== wanted) begin
                        failures++;
                        $error("accepted: expected %0b, actual %0b", wanted, accepted);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_accepts.push_back(screen_packet(source_address, channel,
                                                         command, now_ms));
            // Writes to an index past the register list are ignored.
            if (psel && penable && pwrite && pready &&
                (paddr >> 2) == rpdf_pkg::REG_WINDOW_MS)
                window = pwdata[15:0];
            fail_count  <= failures;
            outstanding <= expected_accepts.size();
        end
    end

endmodule

/* tb/recent_packet_duplicate_filter_unit_tb.sv */
// Top level of the duplicate filter testbench: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module recent_packet_duplicate_filter_unit_tb;

    // Byte address of the window register, and one just past the register list.
    localparam logic [rpdf_pkg::PADDR_W-1:0] ADDR_WINDOW   =
        rpdf_pkg::PADDR_W'(4 * rpdf_pkg::REG_WINDOW_MS);
    localparam logic [rpdf_pkg::PADDR_W-1:0] ADDR_UNMAPPED =
        rpdf_pkg::PADDR_W'(4 * (rpdf_pkg::REG_WINDOW_MS + 1));

    // Cycles without any accepted transaction before the run is declared hung.
    localparam int IDLE_LIMIT      = 1000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] chan;
        logic [7:0]  cmd;
    } pkt_key_t;

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          in_valid       = 1'b0;
    logic [15:0]                   source_address = '0;
    logic [15:0]                   channel        = '0;
    logic [7:0]                    command        = '0;
    logic [31:0]                   now_ms         = '0;
    logic                          out_stall      = 1'b0;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [rpdf_pkg::PADDR_W-1:0]  paddr          = '0;
    logic [rpdf_pkg::PDATA_W-1:0]  pwdata         = '0;

    logic                          in_stall;
    logic                          out_valid;
    logic                          accepted;
    logic [rpdf_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    int                            fail_count;
    int                            outstanding;
    int                            idle_cycles = 0;

    // Sender pacing: a burst counter that is refilled after a random gap.
    int                            burst_left = 0;

    // Receiver pacing: a stall mode that is held for a random number of cycles.
    int                            stall_mode = 0;
    int                            stall_hold = 0;

    // Stimulus shaping state. The packet clock drifts forward in steps that are
    // scaled to the current window so that many repeats land near its edge.
    logic [15:0]                   cur_window = rpdf_pkg::WINDOW_RESET;
    logic [31:0]                   clock_ms   = '0;
    logic [15:0]                   pool_addr [4];
    logic [15:0]                   pool_chan [2];
    logic [7:0]                    pool_cmd  [3];
    pkt_key_t                      recent_keys [$];
    logic [15:0]                   phase_window [NUM_PHASES];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    recent_packet_duplicate_filter_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .source_address (source_address),
        .channel        (channel),
        .command        (command),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // The checker sees exactly what the block sees and keeps its own history.
    rpdf_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .source_address (source_address),
        .channel        (channel),
        .command        (command),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // The receiver alternates between free flow, light random stalls and heavy
    // random stalls. Each mode lasts long enough to span several packets, so the
    // output register is held during every phase of the block's scan.
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(20, 200);
        end
        else
        begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Watchdog: any accepted transaction on either channel or the register port
    // counts as progress. A long stretch without progress means the block hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pwrite && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one packet and holds it until the block takes the transaction.
    // When a burst runs out, valid drops for a random gap before the next burst;
    // a gap of zero keeps valid high so back-to-back packets are covered too.
    task automatic send_packet(input logic [15:0] addr, input logic [15:0] chan,
                               input logic [7:0] cmd, input logic [31:0] stamp);
        int       gap;
        pkt_key_t key;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        source_address <= addr;
        channel        <= chan;
        command        <= cmd;
        now_ms         <= stamp;
        do @(posedge clk); while (in_stall);
        key.addr = addr;
        key.chan = chan;
        key.cmd  = cmd;
        recent_keys.push_back(key);
        if (recent_keys.size() > 12)
            void'(recent_keys.pop_front());
    endtask

    // Stops sending and waits until every verdict has come back, so that the
    // block is idle before the window is changed.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // One APB write: setup cycle, access cycle, then a cycle back at idle so
    // that a following write never reassigns psel within the same time step.
    // The upper data bits carry junk, which the register must ignore.
    task automatic write_reg(input logic [rpdf_pkg::PADDR_W-1:0] addr,
                             input logic [15:0] value);
        logic [31:0] junk;
        junk    = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk[31:16], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_WINDOW)
            cur_window = value;
    endtask

    // Fresh small key pools give each phase its own set of colliding senders.
    task automatic refresh_pools();
        for (int i = 0; i < 4; i++)
            pool_addr[i] = 16'($urandom);
        for (int i = 0; i < 2; i++)
            pool_chan[i] = 16'($urandom);
        for (int i = 0; i < 3; i++)
            pool_cmd[i] = 8'($urandom);
    endtask

    // Most packets reuse a recent or pooled key with a time that moves in
    // window-sized steps, which is what drives the duplicate logic. The rest are
    // noise: every field random, which toggles every bit and mostly passes.
    task automatic random_packet();
        pkt_key_t    key;
        logic [31:0] stamp;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            key.addr = 16'($urandom);
            key.chan = 16'($urandom);
            key.cmd  = 8'($urandom);
            stamp    = $urandom;
        end
        else
        begin
            if (pick < 65 && recent_keys.size() > 0)
            begin
                key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            end
            else
            begin
                key.addr = pool_addr[$urandom_range(0, 3)];
                key.chan = pool_chan[$urandom_range(0, 1)];
                key.cmd  = pool_cmd[$urandom_range(0, 2)];
            end
            pick = $urandom_range(0, 99);
            // The same millisecond again leaves the clock untouched.
            if (pick >= 15 && pick < 60)
                clock_ms = clock_ms + $urandom_range(0, int'(cur_window) / 4 + 1);
            else if (pick >= 60 && pick < 90)
                clock_ms = clock_ms + int'(cur_window) - 2 + $urandom_range(0, 4);
            else if (pick >= 90)
                clock_ms = $urandom;
            stamp = clock_ms;
        end
        send_packet(key.addr, key.chan, key.cmd, stamp);
    endtask

    initial
    begin
        // The window settings of the random phases include both extremes of the
        // register, zero, the reset value and one value drawn at random.
        phase_window[0] = 16'd1;
        phase_window[1] = 16'hFFFF;
        phase_window[2] = 16'd0;
        phase_window[3] = rpdf_pkg::WINDOW_RESET;
        phase_window[4] = 16'd37;
        phase_window[5] = 16'($urandom_range(1, 65535));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset window of 200 ms.
        // An all-zero packet must pass, since no ring entry is valid after reset.
        send_packet(16'h0000, 16'h0000, 8'h00, 32'd0);
        // One millisecond inside the window is a duplicate, the edge itself is not.
        send_packet(16'h0000, 16'h0000, 8'h00, 32'd199);
        send_packet(16'h0000, 16'h0000, 8'h00, 32'd200);
        // All-ones fields, then the same key just after the time counter wraps.
        send_packet(16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_packet(16'hFFFF, 16'hFFFF, 8'hFF, 32'h0000_0005);
        // A stored time ahead of the current one looks very old and must not
        // suppress the packet.
        send_packet(16'h1234, 16'h0000, 8'h00, 32'd1000);
        send_packet(16'h1234, 16'h0000, 8'h00, 32'd999);
        // Eleven distinct packets push the oldest one out of the ring, so it is
        // new again, while the most recent one is still caught.
        for (int i = 0; i <= rpdf_pkg::HISTORY_DEPTH; i++)
            send_packet(16'(16'h0100 + i), 16'h0007, 8'h42, 32'd7000);
        send_packet(16'h0100, 16'h0007, 8'h42, 32'd7000);
        send_packet(16'(16'h0100 + rpdf_pkg::HISTORY_DEPTH), 16'h0007, 8'h42, 32'd7000);

        // Widest window: an age one short of it is still a duplicate.
        drain();
        write_reg(ADDR_WINDOW, 16'hFFFF);
        send_packet(16'(16'h0100 + rpdf_pkg::HISTORY_DEPTH), 16'h0007, 8'h42, 32'd72534);

        // A write past the register list must leave the window alone.
        drain();
        write_reg(ADDR_UNMAPPED, 16'h0001);

        // Narrowest nonzero window: only the very same millisecond repeats.
        write_reg(ADDR_WINDOW, 16'd1);
        send_packet(16'hA5A5, 16'h5A5A, 8'h3C, 32'd500);
        send_packet(16'hA5A5, 16'h5A5A, 8'h3C, 32'd500);
        send_packet(16'hA5A5, 16'h5A5A, 8'h3C, 32'd501);

        // A zero window lets every packet through, even an exact repeat.
        drain();
        write_reg(ADDR_WINDOW, 16'd0);
        send_packet(16'hA5A5, 16'h5A5A, 8'h3C, 32'd501);

        // Random phases, each under its own window setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_reg(ADDR_WINDOW, phase_window[p]);
            if (p == 3)
                write_reg(ADDR_UNMAPPED, 16'($urandom));
            refresh_pools();
            recent_keys.delete();
            // The widest window phase starts just short of the time wrap.
            clock_ms = (p == 1) ? 32'hFFFF_0000 : $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_packet();
        end

        drain();
        repeat (24) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* recent_packet_duplicate_filter_unit.f */
hw/rtl/rpdf_pkg.sv
hw/rtl/rpdf_ram.sv
hw/rtl/recent_packet_duplicate_filter_unit.sv
tb/rpdf_checker.sv
tb/recent_packet_duplicate_filter_unit_tb.sv
